[design/assert_macros.svh]
// assertion helpers used by the checker file rk4_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/rk4_pkg.sv]
// ----------------------------------------------------------------------------
// rk4_pkg
// Shared widths, codes and types of the RK4 ODE stepper.
// ----------------------------------------------------------------------------
package rk4_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int DATA_W        = 32;
  localparam int STEP_W        = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int SUM_W         = 36;

  // divide by three through a shift-and-add reciprocal, one step a cycle
  localparam int DIV_W         = 36;
  localparam int DIV_STEPS     = 6;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
  localparam int DIV_REM_W     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_Y       = 3'd0,
    REG_COEF_X_SQ    = 3'd1,
    REG_COEF_X       = 3'd2,
    REG_COEF_CONST   = 3'd3,
    REG_STEP_SIZE    = 3'd4,
    REG_START_VALUE  = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XX,
    ST_AY,
    ST_BXX,
    ST_CX,
    ST_CX_ADD,
    ST_ADD_D,
    ST_SUM,
    ST_YOP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_INCR_MUL,
    ST_INCR_POST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[design/rk4_in_if.sv]
// ----------------------------------------------------------------------------
// rk4_in_if
// Input channel: one step request per transaction.
// ----------------------------------------------------------------------------
interface rk4_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

[design/rk4_out_if.sv]
// ----------------------------------------------------------------------------
// rk4_out_if
// Result channel: new position and value after one step.
// ----------------------------------------------------------------------------
interface rk4_out_if;
  import rk4_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output position, output value, input ready);
  modport sink (input valid, input position, input value, output ready);
endinterface

[design/rk4_cfg_if.sv]
// ----------------------------------------------------------------------------
// rk4_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rk4_cfg_if;
  import rk4_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/rk4_div3.sv]
// ----------------------------------------------------------------------------
// rk4_div3
// Unsigned divide by three: shift-and-add reciprocal estimate, then a
// small remainder fix, one step per cycle.
// ----------------------------------------------------------------------------
module rk4_div3 (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [rk4_pkg::DIV_W-1:0] dividend,
  output rk4_pkg::div_stat_t       stat,
  output logic [rk4_pkg::DIV_W-1:0] quotient
);
  import rk4_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_ONE  = DIV_CNT_W'(1);
  localparam logic [DIV_CNT_W-1:0] REM_STEP = DIV_CNT_W'(4);

  logic [DIV_W-1:0]     num_r, num_nxt;
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W-1:0]     q_sh;
  logic [DIV_W-1:0]     q_x3;
  logic [DIV_REM_W+3:0] rem_x11;

  // 1/3 = 5/16 * (1 + 2^-4) * (1 + 2^-8) * (1 + 2^-16) * (1 + 2^-32) ...
  always_comb begin
    case (cnt_r)
      DIV_CNT_W'(0): q_sh = q_r >> 4;
      DIV_CNT_W'(1): q_sh = q_r >> 8;
      DIV_CNT_W'(2): q_sh = q_r >> 16;
      default:       q_sh = q_r >> 32;
    endcase
  end

  assign q_x3    = q_r + {q_r[DIV_W-2:0], 1'b0};
  // floor(r * 11 / 32) equals floor(r / 3) for the small remainders left here
  assign rem_x11 = (DIV_REM_W+4)'(rem_r) * (DIV_REM_W+4)'(11);

  always_comb begin
    num_nxt  = num_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = dividend;
      q_nxt    = (dividend >> 2) + (dividend >> 4);
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_ONE;
      if (cnt_r < REM_STEP) begin
        q_nxt = q_r + q_sh;
      end else if (cnt_r == REM_STEP) begin
        // truncation leaves the estimate a few short, never over
        rem_nxt = DIV_REM_W'(num_r - q_x3);
      end else begin
        q_nxt    = q_r + DIV_W'(rem_x11[DIV_REM_W+3:5]);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

[design/rk4_ode_stepper_core.sv]
// ----------------------------------------------------------------------------
// rk4_ode_stepper_core
// Fixed-step fourth-order Runge-Kutta integrator for y' = a*y + b*x^2 + c*x + d.
// ----------------------------------------------------------------------------
// Each input transaction advances x and y by one step h (after an optional
// restart at x = 0, y = start_value) and returns the new pair in signed fixed
// point with FRAC_BITS fraction bits, saturated to 32 bits. A step stalls while
// an earlier result is still waiting, and the next request is taken in the
// cycle the result appears: the twenty products of the four slope evaluations
// and the final update run one after another through a single registered
// 32x32 multiplier, and the weighted slope sum is divided by six with a
// shift-and-add reciprocal. The user must see that configuration is written
// only while idle; the block itself does not enforce it. The configuration
// port is always ready.
module rk4_ode_stepper_core #(
  parameter int FRAC_BITS = rk4_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rk4_cfg_if.sink     cfg_ch,
  rk4_in_if.sink      in_ch,
  rk4_out_if.source   out_ch
);
  import rk4_pkg::*;

  localparam logic [63:0] ONE_WIDE = 64'd1 << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] ONE_Q     = DATA_W'(ONE_WIDE);
  localparam logic signed [DATA_W-1:0] TWO_Q     = DATA_W'(ONE_WIDE << 1);
  localparam logic signed [DATA_W-1:0] NEG_TWO_Q = DATA_W'(64'd0 - (ONE_WIDE << 1));
  localparam logic [STEP_W-1:0]        STEP_RST  = STEP_W'(ONE_WIDE / 1000);
  localparam logic [SUM_W:0]           DIV_OFFSET = (SUM_W + 1)'(64'd6 << 32);
  localparam logic signed [DATA_W-1:0] MAX_Q = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_Q = {1'b1, {(DATA_W-1){1'b0}}};

  state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] coef_y_r, coef_xsq_r, coef_x_r, coef_c_r, start_r;
  logic [STEP_W-1:0]        step_r;
  logic signed [DATA_W-1:0] x_r, y_r, xo_r, yo_r, xx_r, acc_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [63:0]       p_r;
  logic [1:0]               kidx_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_pos_r, out_val_r;

  logic                     mul_en;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [63:0]       prod;
  logic signed [DATA_W-1:0] h_s, half_h_s, xm, xe;
  logic signed [SUM_W-1:0]  acc_ext;
  logic [SUM_W:0]           div_u;
  logic                     div_start;
  div_stat_t                div_stat;
  logic [DIV_W-1:0]         div_quot;
  logic                     in_accept, out_free;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? MIN_Q : MAX_Q;
    end
    return s[DATA_W-1:0];
  endfunction

  // floor shift of a full product back to the fixed-point grid, then clamp
  function automatic logic signed [DATA_W-1:0] fix_post(
    input logic signed [63:0] p,
    input logic               extra
  );
    logic signed [63:0] r;
    r = p >>> (FRAC_BITS + int'(extra));
    if ((&r[63:DATA_W-1]) || !(|r[63:DATA_W-1])) begin
      return r[DATA_W-1:0];
    end
    return r[63] ? MIN_Q : MAX_Q;
  endfunction

  assign h_s      = {1'b0, step_r};
  assign half_h_s = {2'b00, step_r[STEP_W-1:1]};
  assign xm       = sat_add(x_r, half_h_s);
  assign xe       = sat_add(x_r, h_s);
  assign prod     = mul_a * mul_b;
  assign acc_ext  = {{(SUM_W-DATA_W){acc_r[DATA_W-1]}}, acc_r};
  // offset by a multiple of six keeps the dividend nonnegative
  assign div_u    = {sum_r[SUM_W-1], sum_r} + DIV_OFFSET;

  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  rk4_div3 u_div3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_u[SUM_W:1]),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_XX;
      end
      ST_XX: begin
        mul_en    = 1'b1;
        mul_a     = xo_r;
        mul_b     = xo_r;
        state_nxt = ST_AY;
      end
      ST_AY: begin
        mul_en    = 1'b1;
        mul_a     = coef_y_r;
        mul_b     = yo_r;
        state_nxt = ST_BXX;
      end
      ST_BXX: begin
        mul_en    = 1'b1;
        mul_a     = coef_xsq_r;
        mul_b     = xx_r;
        state_nxt = ST_CX;
      end
      ST_CX: begin
        mul_en    = 1'b1;
        mul_a     = coef_x_r;
        mul_b     = xo_r;
        state_nxt = ST_CX_ADD;
      end
      ST_CX_ADD: state_nxt = ST_ADD_D;
      ST_ADD_D:  state_nxt = ST_SUM;
      ST_SUM: begin
        if (kidx_r == 2'd3) begin
          state_nxt = ST_DIV_START;
        end else begin
          mul_en    = 1'b1;
          mul_a     = h_s;
          mul_b     = acc_r;
          state_nxt = ST_YOP;
        end
      end
      ST_YOP: state_nxt = ST_XX;
      ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) state_nxt = ST_INCR_MUL;
      end
      ST_INCR_MUL: begin
        mul_en    = 1'b1;
        mul_a     = h_s;
        mul_b     = div_quot[DATA_W-1:0];
        state_nxt = ST_INCR_POST;
      end
      ST_INCR_POST: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration, integrator state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_y_r    <= NEG_TWO_Q;
      coef_xsq_r  <= TWO_Q;
      coef_x_r    <= TWO_Q;
      coef_c_r    <= '0;
      step_r      <= STEP_RST;
      start_r     <= ONE_Q;
      x_r         <= '0;
      y_r         <= ONE_Q;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_COEF_Y:      coef_y_r   <= cfg_ch.data;
          REG_COEF_X_SQ:   coef_xsq_r <= cfg_ch.data;
          REG_COEF_X:      coef_x_r   <= cfg_ch.data;
          REG_COEF_CONST:  coef_c_r   <= cfg_ch.data;
          REG_STEP_SIZE:   step_r     <= cfg_ch.data[STEP_W-1:0];
          REG_START_VALUE: start_r    <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_accept && in_ch.restart) begin
        x_r <= '0;
        y_r <= start_r;
      end
      if (state_r == ST_INCR_POST) begin
        x_r <= xe;
        y_r <= sat_add(y_r, fix_post(p_r, 1'b0));
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // slope datapath around the shared multiplier
  always_ff @(posedge clk) begin
    if (mul_en) p_r <= prod;
    if (state_r == ST_OUT && out_free) begin
      out_pos_r <= x_r;
      out_val_r <= y_r;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          xo_r   <= in_ch.restart ? '0 : x_r;
          yo_r   <= in_ch.restart ? start_r : y_r;
          sum_r  <= '0;
          kidx_r <= '0;
        end
      end
      ST_AY:  xx_r  <= fix_post(p_r, 1'b0);
      ST_BXX: acc_r <= fix_post(p_r, 1'b0);
      ST_CX, ST_CX_ADD: acc_r <= sat_add(acc_r, fix_post(p_r, 1'b0));
      ST_ADD_D: acc_r <= sat_add(acc_r, coef_c_r);
      ST_SUM: begin
        // middle slopes carry weight two
        if (kidx_r == 2'd1 || kidx_r == 2'd2) begin
          sum_r <= sum_r + (acc_ext <<< 1);
        end else begin
          sum_r <= sum_r + acc_ext;
        end
      end
      ST_YOP: begin
        // first two trial points use half a step, the last one a full step
        yo_r   <= sat_add(y_r, fix_post(p_r, !kidx_r[1]));
        xo_r   <= (kidx_r == 2'd2) ? xe : xm;
        kidx_r <= kidx_r + 2'd1;
      end
      default: ;
    endcase
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.value    = out_val_r;

endmodule

[design/rk4_chk.sv]
// ----------------------------------------------------------------------------
// rk4_chk
// Port-level checks of the RK4 ODE stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rk4_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rk4_pkg::DATA_W-1:0]  out_position,
  input logic [rk4_pkg::DATA_W-1:0]  out_value,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);

  // one step at a time: busy right after taking a transaction
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a result never shows up the cycle after a request is taken
  `ASSERT_IMPL(a_no_early_result, $rose(out_valid), !$past(in_valid && in_ready))

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_position) && $stable(out_value))

  `ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind rk4_ode_stepper_core rk4_chk u_rk4_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_position (out_ch.position),
  .out_value    (out_ch.value),
  .cfg_valid    (cfg_ch.valid),
  .cfg_ready    (cfg_ch.ready)
);
